// ----- rtl/tpac_pkg.sv -----
// Shared types and constants for the TRIAC phase-angle controller.
package tpac_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;

    localparam int SPEED_W = 8;
    localparam int DELAY_W = 16;
    localparam int CROSS_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SPEED_W-1:0] MIN_ON_SPEED = 8'd50;
    localparam logic [SPEED_W-1:0] FULL_SPEED = 8'd100;

    localparam logic [SPEED_W-1:0] SPEED_RST = 8'd0;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 16'd500;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 16'd10000;
    localparam logic [DELAY_W-1:0] PULSE_RST = 16'd100;

    // Division by 50 as multiply by ceil(2^28 / 50) and shift; exact for
    // dividends below 2^22.
    localparam int RECIP_SHIFT = 28;
    localparam logic [22:0] RECIP_MULT = 23'd5368710;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE = 2'd3;

    // Firing setup derived from the configuration registers.
    typedef struct packed {
        logic               speed_on;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] pulse_width;
    } t_fire_cfg;

endpackage

// ----- rtl/tpac_delay_calc.sv -----
// Three-stage pipeline that turns speed and delay limits into a firing delay.
module tpac_delay_calc
    import tpac_pkg::*;
(
    input  logic               i_clk,
    input  logic [SPEED_W-1:0] i_speed,
    input  logic [DELAY_W-1:0] i_max_delay,
    input  logic [DELAY_W-1:0] i_min_delay,
    output logic [DELAY_W-1:0] o_delay
);

    // Stage A: clamp the speed and form span * (speed - 50).
    logic [SPEED_W-1:0] s_eff;
    logic               s_off;
    logic signed [16:0] s_span;
    logic signed [6:0]  s_frac;

    logic signed [23:0] r_prod_a;
    logic               r_off_a;
    logic [DELAY_W-1:0] r_lo_a;

    // Stage B: magnitude divided by 50.
    logic [21:0] s_mag;
    logic [44:0] s_recip;

    logic [16:0]        r_quot_b;
    logic               r_neg_b;
    logic               r_off_b;
    logic [DELAY_W-1:0] r_lo_b;

    logic [DELAY_W-1:0] n_delay;
    logic [DELAY_W-1:0] r_delay;

    always_comb begin
        s_off = (i_speed == '0);
        if (i_speed < MIN_ON_SPEED) begin
            s_eff = MIN_ON_SPEED;
        end else if (i_speed > FULL_SPEED) begin
            s_eff = FULL_SPEED;
        end else begin
            s_eff = i_speed;
        end
        s_span = signed'({1'b0, i_min_delay}) - signed'({1'b0, i_max_delay});
        s_frac = signed'(7'(s_eff - MIN_ON_SPEED));
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= 24'(s_span * s_frac);
        r_off_a  <= s_off;
        r_lo_a   <= i_min_delay;
    end

    always_comb begin
        s_mag   = r_prod_a[23] ? 22'(-r_prod_a) : 22'(r_prod_a);
        s_recip = 45'(s_mag) * 45'(RECIP_MULT);
    end

    always_ff @(posedge i_clk) begin
        r_quot_b <= s_recip[RECIP_SHIFT +: 17];
        r_neg_b  <= r_prod_a[23];
        r_off_b  <= r_off_a;
        r_lo_b   <= r_lo_a;
    end

    // Stage C: apply the signed step; with speed off the delay is the
    // minimum-power delay itself.
    always_comb begin
        if (r_off_b) begin
            n_delay = r_lo_b;
        end else if (r_neg_b) begin
            n_delay = 16'(17'(r_lo_b) + r_quot_b);
        end else begin
            n_delay = 16'(17'(r_lo_b) - r_quot_b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay <= n_delay;
    end

    assign o_delay = r_delay;

endmodule

// ----- rtl/tpac_phase_core.sv -----
// Per-tick gate timing state with the registered result stage.
module tpac_phase_core
    import tpac_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_fire_cfg          i_cfg,
    input  logic               i_hold,
    input  logic               i_in_valid,
    input  logic               i_zero_cross,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_gate,
    output logic [DELAY_W-1:0] o_firing_delay,
    output logic [CROSS_W-1:0] o_cross_total
);

    logic                  s_accept;
    logic [TIMER_BITS-1:0] s_width;

    logic                  r_valid;
    logic                  n_valid;
    logic [COUNT_BITS-1:0] r_cross;
    logic [COUNT_BITS-1:0] n_cross;
    logic [TIMER_BITS-1:0] r_delay_cnt;
    logic [TIMER_BITS-1:0] n_delay_cnt;
    logic [TIMER_BITS-1:0] r_pulse_cnt;
    logic [TIMER_BITS-1:0] n_pulse_cnt;
    logic                  r_armed;
    logic                  n_armed;
    logic                  r_gate;
    logic                  n_gate;
    logic [DELAY_W-1:0]    r_out_delay;
    logic [DELAY_W-1:0]    n_out_delay;

    assign o_in_ready = (!r_valid || i_out_ready) && !i_hold;
    assign s_accept   = i_in_valid && o_in_ready;

    always_comb begin
        s_width = TIMER_BITS'(i_cfg.pulse_width);
        if (s_width == '0) begin
            s_width = TIMER_BITS'(1);
        end
    end

    always_comb begin
        n_valid     = r_valid;
        n_cross     = r_cross;
        n_delay_cnt = r_delay_cnt;
        n_pulse_cnt = r_pulse_cnt;
        n_armed     = r_armed;
        n_gate      = r_gate;
        n_out_delay = r_out_delay;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        if (s_accept) begin
            n_valid     = 1'b1;
            n_out_delay = i_cfg.delay;
            if (i_zero_cross) begin
                n_cross = r_cross + COUNT_BITS'(1);
            end
            if (!i_cfg.speed_on) begin
                n_gate      = 1'b0;
                n_armed     = 1'b0;
                n_pulse_cnt = '0;
                n_delay_cnt = '0;
            end else if (i_zero_cross) begin
                n_gate      = 1'b0;
                n_pulse_cnt = '0;
                n_delay_cnt = TIMER_BITS'(i_cfg.delay);
                n_armed     = 1'b1;
            end else if (r_gate) begin
                n_pulse_cnt = r_pulse_cnt - TIMER_BITS'(1);
                if (n_pulse_cnt == '0) begin
                    n_gate = 1'b0;
                end
            end else if (r_armed) begin
                if (r_delay_cnt == '0) begin
                    n_gate      = 1'b1;
                    n_pulse_cnt = s_width;
                    n_armed     = 1'b0;
                end else begin
                    n_delay_cnt = r_delay_cnt - TIMER_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cross     <= '0;
            r_delay_cnt <= '0;
            r_pulse_cnt <= '0;
            r_armed     <= 1'b0;
            r_gate      <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_cross     <= n_cross;
            r_delay_cnt <= n_delay_cnt;
            r_pulse_cnt <= n_pulse_cnt;
            r_armed     <= n_armed;
            r_gate      <= n_gate;
        end
        r_out_delay <= n_out_delay;
    end

    assign o_out_valid    = r_valid;
    assign o_gate         = r_gate;
    assign o_firing_delay = r_out_delay;
    assign o_cross_total  = CROSS_W'(r_cross);

    // A tick with speed off always leaves the gate low.
    a_off_gate_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !i_cfg.speed_on) |=> !r_gate)
        else $error("gate high after a tick with speed off");

    // A zero-cross always drops the gate.
    a_zc_gate_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_zero_cross) |=> !r_gate)
        else $error("gate high after a zero-cross");

    // The pulse and the pending delay never coexist.
    a_gate_not_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate |-> !r_armed)
        else $error("gate high while a delay is still armed");

    // Each accepted zero-cross adds exactly one to the crossing count.
    a_cross_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_zero_cross) |=> (r_cross == $past(r_cross) + COUNT_BITS'(1)))
        else $error("crossing count did not advance by one");

endmodule

// ----- rtl/triac_phase_angle_controller_top.sv -----
// Top level of the TRIAC phase-angle controller: registers, delay pipeline and tick core.
//
// Each request on the input stream is one timer tick (nominally one microsecond)
// carrying a zero-cross flag in bit 0 of s_axis_tdata, and each one yields exactly
// one result holding the gate level after that tick, the firing delay in use and
// the running zero-cross count. The block takes one tick per clock cycle unless a
// configuration write or a stalled output holds it, and a taken tick's result is
// registered in the next cycle; the output register lets a new tick enter in the
// same cycle that the previous result is taken. The speed setting is clamped to off
// or 50..100 percent and mapped onto a delay between min_power_delay and
// max_power_delay by a three-stage pipeline (clamp and multiply, divide by 50
// through a reciprocal multiply, final add), so a busy count holds s_axis_tready low
// after reset and after every configuration write; configuration writes are
// always taken (o_cfg_ready is high) and must only be made while no result is
// outstanding. A zero-cross captures the delay; when it has elapsed the gate goes
// high for pulse_width ticks (a width of zero counts as one). A zero-cross during a
// delay or a pulse restarts the delay with the gate low, and speed off holds the
// gate low and cancels any pending firing.
module triac_phase_angle_controller_top
    import tpac_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data,
    // Tick input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] zero_cross, [7:1] zero
    // Result output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata    // [0] gate, [16:1] firing_delay,
                                                 // [48:17] cross_total, [55:49] zero
);

    localparam logic [1:0] PIPE_WAIT = 2'd3;

    logic [SPEED_W-1:0] r_speed;
    logic [DELAY_W-1:0] r_max_delay;
    logic [DELAY_W-1:0] r_min_delay;
    logic [DELAY_W-1:0] r_pulse;
    logic [1:0]         r_busy;
    logic [1:0]         n_busy;
    logic               s_cfg_wr;

    t_fire_cfg          s_fire;
    logic [DELAY_W-1:0] s_delay;
    logic               s_gate;
    logic [DELAY_W-1:0] s_firing_delay;
    logic [CROSS_W-1:0] s_cross_total;

    assign o_cfg_ready = 1'b1;
    assign s_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // The busy count covers the delay pipeline latency after each write.
    always_comb begin
        n_busy = r_busy;
        if (s_cfg_wr) begin
            n_busy = PIPE_WAIT;
        end else if (r_busy != '0) begin
            n_busy = r_busy - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_RST;
            r_max_delay <= MAX_DELAY_RST;
            r_min_delay <= MIN_DELAY_RST;
            r_pulse     <= PULSE_RST;
            r_busy      <= PIPE_WAIT;
        end else begin
            r_busy <= n_busy;
            if (s_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_SPEED:     r_speed     <= i_cfg_data[SPEED_W-1:0];
                    REG_MAX_DELAY: r_max_delay <= i_cfg_data;
                    REG_MIN_DELAY: r_min_delay <= i_cfg_data;
                    REG_PULSE:     r_pulse     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    tpac_delay_calc u_delay_calc (
        .i_clk       (i_clk),
        .i_speed     (r_speed),
        .i_max_delay (r_max_delay),
        .i_min_delay (r_min_delay),
        .o_delay     (s_delay)
    );

    always_comb begin
        s_fire.speed_on    = (r_speed != '0);
        s_fire.delay       = s_delay;
        s_fire.pulse_width = r_pulse;
    end

    tpac_phase_core #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_phase_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (s_fire),
        .i_hold         (r_busy != '0),
        .i_in_valid     (s_axis_tvalid),
        .i_zero_cross   (s_axis_tdata[0]),
        .o_in_ready     (s_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_gate         (s_gate),
        .o_firing_delay (s_firing_delay),
        .o_cross_total  (s_cross_total)
    );

    assign m_axis_tdata = {7'd0, s_cross_total, s_firing_delay, s_gate};

endmodule

// ----- tb/triac_phase_angle_controller_top_test.sv -----
// Self-checking testbench for the TRIAC phase-angle controller top level.
module triac_phase_angle_controller_top_test
    import tpac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 36;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 75;

    // One result item: the gate level after a tick, the delay in use and the crossing count.
    typedef struct packed {
        logic               gate;
        logic [DELAY_W-1:0] firing_delay;
        logic [CROSS_W-1:0] cross_total;
    } t_tick_result;

    // Tracks the expected gate behavior tick by tick and checks every result against it.
    class tick_scoreboard;
        logic [SPEED_W-1:0] speed_reg     = SPEED_RST;
        logic [DELAY_W-1:0] max_delay_reg = MAX_DELAY_RST;
        logic [DELAY_W-1:0] min_delay_reg = MIN_DELAY_RST;
        logic [DELAY_W-1:0] pulse_reg     = PULSE_RST;

        logic [CROSS_W-1:0] crossings  = '0;
        logic [DELAY_W-1:0] delay_left = '0;
        logic [DELAY_W-1:0] pulse_left = '0;
        bit                 armed      = 1'b0;
        bit                 gate_on    = 1'b0;

        t_tick_result expected_ticks[$];
        int           mismatches = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
            case (idx)
                REG_SPEED:     speed_reg = data[SPEED_W-1:0];
                REG_MAX_DELAY: max_delay_reg = data;
                REG_MIN_DELAY: min_delay_reg = data;
                REG_PULSE:     pulse_reg = data;
                default: ;
            endcase
        endfunction

        // Advances the gate timing by one tick and queues the result it must produce.
        function void take_tick(bit zc);
            longint             pct;
            longint             lo;
            longint             hi;
            longint             step;
            logic [DELAY_W-1:0] delay;
            t_tick_result       res;
            // Clamp the speed to off or the 50..100 percent band.
            if (speed_reg == '0) begin
                pct = 0;
            end else if (speed_reg < MIN_ON_SPEED) begin
                pct = longint'(MIN_ON_SPEED);
            end else if (speed_reg > FULL_SPEED) begin
                pct = longint'(FULL_SPEED);
            end else begin
                pct = longint'(speed_reg);
            end
            lo = longint'(min_delay_reg);
            hi = longint'(max_delay_reg);
            // Signed division truncates toward zero, also when the delays are reversed.
            if (pct == 0) begin
                delay = min_delay_reg;
            end else begin
                step = ((lo - hi) * (pct - longint'(MIN_ON_SPEED)))
                       / longint'(FULL_SPEED - MIN_ON_SPEED);
                delay = DELAY_W'(lo - step);
            end
            if (zc) begin
                crossings = crossings + 1'b1;
            end
            if (pct == 0) begin
                gate_on    = 1'b0;
                armed      = 1'b0;
                pulse_left = '0;
                delay_left = '0;
            end else if (zc) begin
                gate_on    = 1'b0;
                pulse_left = '0;
                delay_left = delay;
                armed      = 1'b1;
            end else if (gate_on) begin
                pulse_left = pulse_left - 1'b1;
                if (pulse_left == '0) begin
                    gate_on = 1'b0;
                end
            end else if (armed) begin
                if (delay_left == '0) begin
                    // A zero pulse width still gives a one-tick pulse.
                    pulse_left = (pulse_reg == '0) ? DELAY_W'(1) : pulse_reg;
                    gate_on    = 1'b1;
                    armed      = 1'b0;
                end else begin
                    delay_left = delay_left - 1'b1;
                end
            end
            res.gate         = gate_on;
            res.firing_delay = delay;
            res.cross_total  = crossings;
            expected_ticks.push_back(res);
        endfunction

        function void check_output(logic [55:0] data);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                $display("%0t: result with nothing expected, data %h", $time, data);
                mismatches++;
                return;
            end
            want = expected_ticks.pop_front();
            if (data[0] !== want.gate) begin
                $display("%0t: gate expected %0d actual %0d", $time, want.gate, data[0]);
                mismatches++;
            end
            if (data[16:1] !== want.firing_delay) begin
                $display("%0t: firing_delay expected %0d actual %0d",
                         $time, want.firing_delay, data[16:1]);
                mismatches++;
            end
            if (data[48:17] !== want.cross_total) begin
                $display("%0t: cross_total expected %0d actual %0d",
                         $time, want.cross_total, data[48:17]);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SPEED;
    logic [DELAY_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;    // [0] zero_cross, [7:1] zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [55:0]          m_axis_tdata;         // [0] gate, [16:1] firing_delay,
                                                // [48:17] cross_total, [55:49] zero

    // While calm is set, neither the tick source nor the result sink ever pauses.
    bit             calm = 1'b0;
    int             stall_cycles = 0;
    tick_scoreboard sb;

    triac_phase_angle_controller_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The result sink applies back-pressure at random, changing only on falling edges.
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Everything is sampled on the rising edge, where the handshakes complete. Register
    // writes update the predictor right away, since they only happen while the block is idle.
    // The watchdog counts cycles in which no request of any kind moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_tick(s_axis_tdata[0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_output(m_axis_tdata);
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offers one tick request, after a random number of idle cycles unless calm is set.
    // Called and returns on a falling edge; tvalid stays high for a following request.
    task automatic send_tick(input bit zc);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, zc};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Writes one register; the caller lowers the valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Lets every outstanding result drain, then writes the registers selected in sel
    // (bit 0 speed, bit 1 max delay, bit 2 min delay, bit 3 pulse width). Every tick
    // yields a result, so an empty queue means the block is idle; the few extra cycles
    // only add margin.
    task automatic configure(input logic [3:0] sel, input logic [DELAY_W-1:0] speed,
                             input logic [DELAY_W-1:0] maxd, input logic [DELAY_W-1:0] mind,
                             input logic [DELAY_W-1:0] pulse);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
        if (sel[0]) begin
            write_reg(REG_SPEED, speed);
        end
        if (sel[1]) begin
            write_reg(REG_MAX_DELAY, maxd);
        end
        if (sel[2]) begin
            write_reg(REG_MIN_DELAY, mind);
        end
        if (sel[3]) begin
            write_reg(REG_PULSE, pulse);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                 ph;
        int                 n;
        int                 period;
        int                 since;
        int                 pick;
        bit                 noisy;
        bit                 zc;
        logic [DELAY_W-1:0] speed;
        logic [DELAY_W-1:0] maxd;
        logic [DELAY_W-1:0] mind;
        logic [DELAY_W-1:0] pulse;

        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values leave the speed off: the gate stays low whatever the crossings do,
        // and firing_delay reports the minimum-power delay.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);

        // Full speed with a zero delay fires on the tick after the crossing, and a zero
        // pulse width gives a pulse of a single tick.
        configure(4'b1111, 16'd100, 16'd0, 16'd2, 16'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // Reversed delays (max above min) at 75 percent give a delay of four ticks. The
        // crossing near the end lands inside the pulse and must restart the delay.
        configure(4'b1111, 16'd75, 16'd6, 16'd2, 16'd3);
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // Speed above 100 clamps to full speed; here that yields the largest delay.
        configure(4'b1111, 16'd255, 16'hFFFF, 16'd0, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);

        // Speed 1 clamps to 50, so the delay is the minimum-power one, which is zero here:
        // the gate rises and would stay high for the longest pulse.
        configure(4'b0001, 16'd1, '0, '0, '0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Turning the speed off must cancel the pulse in progress on the next tick.
        configure(4'b0001, 16'd0, '0, '0, '0);
        send_tick(1'b0);
        send_tick(1'b1);

        // Random phases. Most use regular mains-like crossing trains with small delays so
        // the gate really fires; some use noisy crossings, some carry extreme settings.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                speed = {8'($urandom_range(0, 255)), 8'd0};
            end else if (pick <= 2) begin
                speed = 16'($urandom_range(1, 49));
            end else if (pick <= 7) begin
                speed = 16'($urandom_range(50, 100));
            end else begin
                speed = 16'($urandom_range(101, 255));
            end
            // Now and then the unused upper bits of the speed write are set too.
            if ($urandom_range(0, 4) == 0) begin
                speed[15:8] = 8'($urandom_range(0, 255));
            end
            maxd  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            mind  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            pulse = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            if (ph == 0) begin
                // Full speed with max 0 and min at the top: zero delay, longest pulse.
                speed = 16'd100;
                maxd  = 16'd0;
                mind  = 16'hFFFF;
                pulse = 16'hFFFF;
            end else if (ph == 1) begin
                // Lowest on speed with max at the top and min 0: zero delay again.
                speed = 16'd50;
                maxd  = 16'hFFFF;
                mind  = 16'd0;
                pulse = 16'd0;
            end
            configure((ph < 2) ? 4'b1111 : 4'($urandom_range(1, 15)), speed, maxd, mind, pulse);

            calm   = (ph == 4);
            noisy  = ($urandom_range(0, 4) == 0);
            period = $urandom_range(3, 80);
            since  = 0;
            for (n = 0; n < PHASE_TICKS; n++) begin
                if (noisy) begin
                    zc = ($urandom_range(0, 99) < 30);
                end else begin
                    zc = (since >= period) || ($urandom_range(0, 99) < 3);
                end
                since = zc ? 0 : since + 1;
                send_tick(zc);
            end
            calm = 1'b0;
        end

        // Drain: wait for every result, then a few cycles for anything unexpected.
        s_axis_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (5) @(negedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- triac_phase_angle_controller_top.f -----
rtl/tpac_pkg.sv
rtl/tpac_delay_calc.sv
rtl/tpac_phase_core.sv
rtl/triac_phase_angle_controller_top.sv
tb/triac_phase_angle_controller_top_test.sv
